### rtl/core/srld_pkg.sv
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types and codes of the run-length sprite decoder: command codes,
// decode phases, register indexes and the run descriptor passed from the
// byte decoder to the pixel emitter.
// ----------------------------------------------------------------------------
package srld_pkg;

   // Control byte layout: command in bits 7..6, count in bits 5..0
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 6;

   localparam logic [CMD_W-1:0] CMD_TRANSPARENT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LITERAL     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PLAYER      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COLOUR      = 2'd3;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int DIM_W       = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENT_CODE = 2'd2;

   // Output field widths
   localparam int POS_W    = 10;
   localparam int COLOUR_W = 8;

   // Decode phase
   typedef enum logic [1:0] {
      PH_CONTROL = 2'd0,
      PH_LITERAL = 2'd1,
      PH_VALUE   = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   // One run of pixels on a single row
   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [POS_W-1:0]    x;
      logic [POS_W-1:0]    y;
      logic [COLOUR_W-1:0] colour;
      logic [COLOUR_W-1:0] shade;
      logic                done;
   } run_desc_type;

endpackage

### rtl/core/srld_decode.sv
// ----------------------------------------------------------------------------
// srld_decode
// Byte decoder: holds the registers, the decode phase and the pixel
// position, and turns each transferred byte into one run descriptor.
// Position advances by the whole run at once (one add and compare).
// ----------------------------------------------------------------------------
module srld_decode #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [srld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srld_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                byte_accept,
   input  logic [7:0]                          stream_byte,
   output srld_pkg::run_desc_type              run_desc,
   output logic                                frame_finished
);

   // Compare widths hold the dimension registers and MAX values
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > srld_pkg::DIM_W) ? WW : srld_pkg::DIM_W;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = (HW > srld_pkg::DIM_W) ? HW : srld_pkg::DIM_W;
   localparam int YW = $clog2(MAX_HEIGHT);

   // Registers
   logic [srld_pkg::DIM_W-1:0]    width_cfg_ff;
   logic [srld_pkg::DIM_W-1:0]    height_cfg_ff;
   logic [srld_pkg::COLOUR_W-1:0] tcode_ff;

   // Decode state
   srld_pkg::phase_type            phase_ff, phase_in;
   logic                           kind_player_ff, kind_player_in;
   logic [srld_pkg::COUNT_W-1:0]   remaining_ff, remaining_in;
   logic [XW-1:0]                  col_ff, col_in;
   logic [YW-1:0]                  row_ff, row_in;
   logic                           finished_ff, finished_in;

   // Datapath
   logic [CW-1:0]                  w_cfg, w_eff, col_ext, c0, avail, newcol;
   logic [RW-1:0]                  h_cfg, h_eff, r0, r0_next;
   logic                           wrap, out_of_rows, active, end_row, last_row;
   logic [srld_pkg::CMD_W-1:0]     cmd;
   logic [srld_pkg::COUNT_W-1:0]   cnt, run_req, run_n, rem_dec;
   logic [srld_pkg::COLOUR_W-1:0]  run_colour, run_shade;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= srld_pkg::DIM_W'(1);
         height_cfg_ff <= srld_pkg::DIM_W'(1);
         tcode_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            srld_pkg::CSR_IMAGE_WIDTH:      width_cfg_ff  <= csr_wr_data;
            srld_pkg::CSR_IMAGE_HEIGHT:     height_cfg_ff <= csr_wr_data;
            srld_pkg::CSR_TRANSPARENT_CODE: tcode_ff      <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // Effective dimensions: zero acts as one, clamp at the maximum
   always_comb begin
      w_cfg = CW'(width_cfg_ff);
      h_cfg = RW'(height_cfg_ff);
      if (w_cfg == '0)                    w_eff = CW'(1);
      else if (w_cfg > CW'(MAX_WIDTH))    w_eff = CW'(MAX_WIDTH);
      else                                w_eff = w_cfg;
      if (h_cfg == '0)                    h_eff = RW'(1);
      else if (h_cfg > RW'(MAX_HEIGHT))   h_eff = RW'(MAX_HEIGHT);
      else                                h_eff = h_cfg;
   end

   // Position before the byte: wrap a column left beyond a shrunk width
   assign col_ext     = CW'(col_ff);
   assign wrap        = (col_ext >= w_eff);
   assign c0          = wrap ? '0 : col_ext;
   assign r0          = wrap ? (RW'(row_ff) + RW'(1)) : RW'(row_ff);
   assign out_of_rows = (r0 >= h_eff);
   assign active      = !finished_ff && !out_of_rows;
   assign avail       = w_eff - c0;

   assign cmd     = stream_byte[7:6];
   assign cnt     = stream_byte[5:0];
   assign rem_dec = remaining_ff - srld_pkg::COUNT_W'(1);

   // Run request for this byte (outputs of the phase machine)
   always_comb begin
      run_req    = '0;
      run_colour = tcode_ff;
      run_shade  = tcode_ff;
      unique case (phase_ff)
         srld_pkg::PH_LITERAL: begin
            run_req    = srld_pkg::COUNT_W'(1);
            run_colour = stream_byte;
         end
         srld_pkg::PH_VALUE: begin
            run_req = remaining_ff;
            if (kind_player_ff) run_shade  = stream_byte;
            else                run_colour = stream_byte;
         end
         srld_pkg::PH_CONTROL: begin
            if (cmd == srld_pkg::CMD_TRANSPARENT) run_req = cnt;
         end
         default: ;
      endcase
   end

   // Clip the run at the row end; advance the position by the run
   always_comb begin
      if (!active)                  run_n = '0;
      else if (CW'(run_req) < avail) run_n = run_req;
      else                          run_n = avail[srld_pkg::COUNT_W-1:0];
      newcol   = c0 + CW'(run_n);
      end_row  = (run_n != '0) && (newcol == w_eff);
      r0_next  = r0 + RW'(1);
      last_row = (r0_next >= h_eff);
   end

   // Next phase
   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      kind_player_in = kind_player_ff;
      if (active) begin
         unique case (phase_ff)
            srld_pkg::PH_CONTROL: begin
               priority if (cmd == srld_pkg::CMD_TRANSPARENT) begin
                  phase_in = srld_pkg::PH_CONTROL;
               end else if (cmd == srld_pkg::CMD_LITERAL) begin
                  if (cnt != '0) begin
                     phase_in     = srld_pkg::PH_LITERAL;
                     remaining_in = cnt;
                  end
               end else begin
                  phase_in       = srld_pkg::PH_VALUE;
                  kind_player_in = (cmd == srld_pkg::CMD_PLAYER);
                  remaining_in   = cnt;
               end
            end
            srld_pkg::PH_LITERAL: begin
               remaining_in = rem_dec;
               priority if (rem_dec == '0 || (end_row && last_row))
                  phase_in = srld_pkg::PH_CONTROL;
               else if (end_row)
                  phase_in = srld_pkg::PH_SKIP;
               else
                  phase_in = srld_pkg::PH_LITERAL;
            end
            srld_pkg::PH_VALUE: begin
               phase_in     = srld_pkg::PH_CONTROL;
               remaining_in = '0;
            end
            srld_pkg::PH_SKIP: begin
               remaining_in = rem_dec;
               if (rem_dec == '0) phase_in = srld_pkg::PH_CONTROL;
            end
            default: ;
         endcase
      end
   end

   // Next position and frame status
   always_comb begin
      col_in      = end_row ? '0 : newcol[XW-1:0];
      row_in      = (end_row && !last_row) ? r0_next[YW-1:0] : r0[YW-1:0];
      finished_in = out_of_rows || (end_row && last_row);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= srld_pkg::PH_CONTROL;
         kind_player_ff <= 1'b0;
         remaining_ff   <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         finished_ff    <= 1'b0;
      end else if (byte_accept && !finished_ff) begin
         phase_ff       <= phase_in;
         kind_player_ff <= kind_player_in;
         remaining_ff   <= remaining_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         finished_ff    <= finished_in;
      end
   end

   // Descriptor for the emitter
   always_comb begin
      run_desc.count  = run_n;
      run_desc.x      = c0[srld_pkg::POS_W-1:0];
      run_desc.y      = r0[srld_pkg::POS_W-1:0];
      run_desc.colour = run_colour;
      run_desc.shade  = run_shade;
      run_desc.done   = end_row && last_row;
   end

   assign frame_finished = finished_ff;

endmodule

### rtl/core/srld_emit.sv
// ----------------------------------------------------------------------------
// srld_emit
// Pixel emitter: holds one run descriptor and sends its pixels, one per cycle
// while rsp does not stall, through the result register. A new run loads
// while the last pixel of the current one moves into the result register.
// ----------------------------------------------------------------------------
module srld_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_load,
   input  srld_pkg::run_desc_type        run_desc,
   output logic                          run_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srld_pkg::POS_W-1:0]    rsp_pixel_x,
   output logic [srld_pkg::POS_W-1:0]    rsp_pixel_y,
   output logic [srld_pkg::COLOUR_W-1:0] rsp_colour_index,
   output logic [srld_pkg::COLOUR_W-1:0] rsp_player_shade,
   output logic                          rsp_run_last,
   output logic                          rsp_image_done
);

   // Current run
   logic [srld_pkg::COUNT_W-1:0]  run_left_ff, run_left_in;
   logic [srld_pkg::POS_W-1:0]    run_x_ff, run_x_in;
   logic [srld_pkg::POS_W-1:0]    run_y_ff;
   logic [srld_pkg::COLOUR_W-1:0] run_colour_ff, run_shade_ff;
   logic                          run_done_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic [srld_pkg::POS_W-1:0]    pix_x_ff, pix_y_ff;
   logic [srld_pkg::COLOUR_W-1:0] pix_colour_ff, pix_shade_ff;
   logic                          pix_last_ff, pix_done_ff;

   logic                          out_free, move, final_pixel;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign move        = (run_left_ff != '0) && out_free;
   assign final_pixel = (run_left_ff == srld_pkg::COUNT_W'(1));
   assign run_ready   = (run_left_ff == '0) || (final_pixel && out_free);

   // Run counter and column step
   always_comb begin
      run_left_in = run_left_ff;
      run_x_in    = run_x_ff;
      if (run_load) begin
         run_left_in = run_desc.count;
         run_x_in    = run_desc.x;
      end else if (move) begin
         run_left_in = run_left_ff - srld_pkg::COUNT_W'(1);
         run_x_in    = run_x_ff + srld_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_left_ff <= '0;
      end else begin
         run_left_ff <= run_left_in;
      end
   end

   // Run payload
   always_ff @(posedge clock) begin
      run_x_ff <= run_x_in;
      if (run_load) begin
         run_y_ff      <= run_desc.y;
         run_colour_ff <= run_desc.colour;
         run_shade_ff  <= run_desc.shade;
         run_done_ff   <= run_desc.done;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (move) begin
         pix_x_ff      <= run_x_ff;
         pix_y_ff      <= run_y_ff;
         pix_colour_ff <= run_colour_ff;
         pix_shade_ff  <= run_shade_ff;
         pix_last_ff   <= final_pixel;
         pix_done_ff   <= run_done_ff && final_pixel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = pix_x_ff;
   assign rsp_pixel_y      = pix_y_ff;
   assign rsp_colour_index = pix_colour_ff;
   assign rsp_player_shade = pix_shade_ff;
   assign rsp_run_last     = pix_last_ff;
   assign rsp_image_done   = pix_done_ff;

endmodule

### rtl/core/sprite_rle_player_layer_decoder.sv
// ----------------------------------------------------------------------------
// sprite_rle_player_layer_decoder
// Run-length sprite decoder with a player-colour layer. Takes the compressed
// byte stream and gives one pixel per transfer in raster order.
//
//   channel | ports                    | direction | carries
//   req     | req_valid/req_stall      | in        | stream_byte
//   rsp     | rsp_valid/rsp_stall      | out       | pixel, run_last, image_done
//   csr     | csr_wr_en/index/wr_data  | in        | register writes
//
// A byte is decoded in the cycle it transfers; its pixels follow through
// the emitter's run register and then the result register, one per cycle
// while rsp does not stall. Without rsp stalls, the pixel emitter sends one
// pixel per cycle and takes the next byte as its last pixel moves out.
// Bytes with no pixels transfer one per cycle. Reset is synchronous;
// registers return to width 1, height 1, code 0. A stall on rsp holds the
// result register; req stalls while the loaded run still has pixels
// waiting to move out.
// ----------------------------------------------------------------------------
module sprite_rle_player_layer_decoder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration
   input  logic                                csr_wr_en,
   input  logic [srld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srld_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   // Byte stream
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_stream_byte,
   // Pixels
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [srld_pkg::POS_W-1:0]          rsp_pixel_x,
   output logic [srld_pkg::POS_W-1:0]          rsp_pixel_y,
   output logic [srld_pkg::COLOUR_W-1:0]       rsp_colour_index,
   output logic [srld_pkg::COLOUR_W-1:0]       rsp_player_shade,
   output logic                                rsp_run_last,
   output logic                                rsp_image_done
);

   srld_pkg::run_desc_type run_desc;
   logic                   run_ready;
   logic                   req_accept;
   logic                   frame_finished;

   assign req_stall  = !run_ready;
   assign req_accept = req_valid && run_ready;

   // Byte decoder
   srld_decode #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .byte_accept    (req_accept),
      .stream_byte    (req_stream_byte),
      .run_desc       (run_desc),
      .frame_finished (frame_finished)
   );

   // Pixel emitter
   srld_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .run_load         (req_accept),
      .run_desc         (run_desc),
      .run_ready        (run_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_colour_index (rsp_colour_index),
      .rsp_player_shade (rsp_player_shade),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done)
   );

`ifndef SYNTHESIS
   // The final pixel always closes its run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_run_last)
      else $error("image_done without run_last");

   // The final pixel can only come from a finished frame
   a_done_frame_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> frame_finished)
      else $error("image_done before frame finished");

   // Nothing follows the final pixel
   a_quiet_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_image_done |=> !rsp_valid)
      else $error("pixel after end of image");
`endif

endmodule
